// ===== src/pta_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pta_pkg: shared types and constants for the polygon territory assigner
// Sizes of the vertex store, datapath widths, codes and control structs.
// ----------------------------------------------------------------------------
package pta_pkg;

	// storage geometry
	localparam int MAX_TERR    = 16;
	localparam int MAX_VTX     = 32;
	localparam int TERR_W      = 4;
	localparam int VTX_W       = 5;
	localparam int VADDR_W     = TERR_W + VTX_W;
	localparam int VSTORE_D    = MAX_TERR * MAX_VTX;
	localparam int CLASS_SLOTS = MAX_TERR + 2;
	localparam int CLS_W       = 5;

	// arithmetic widths
	localparam int COORD_W  = 48;
	localparam int DIFF_W   = COORD_W + 1;
	localparam int CHUNK_W  = 25;
	localparam int PROD_W   = 2 * CHUNK_W;
	localparam int ACC_W    = 2 * DIFF_W + 2;
	localparam int NUM_DIFF = 6;
	localparam int CNT_W    = 32;
	localparam int SUM_W    = 40;
	localparam int CSIZE_W  = 24;
	localparam int CELL_W   = 20;

	localparam logic [CSIZE_W-1:0] CELL_SIZE_RESET = CSIZE_W'(25600);
	localparam logic [CLS_W-1:0]   CLS_UNASSIGNED  = CLS_W'(MAX_TERR);
	localparam logic [CLS_W-1:0]   CLS_OVERLAP     = CLS_W'(MAX_TERR + 1);

	typedef enum logic [2:0] {
		CMD_WRITE_VTX   = 3'd0,
		CMD_SET_COUNT   = 3'd1,
		CMD_CLASSIFY    = 3'd2,
		CMD_READ_STATS  = 3'd3,
		CMD_CLEAR_STATS = 3'd4
	} cmd_code_t;

	typedef enum logic [2:0] {
		KIND_TERRITORY  = 3'd0,
		KIND_UNASSIGNED = 3'd1,
		KIND_OVERLAP    = 3'd2,
		KIND_DONE       = 3'd3,
		KIND_SKIPPED    = 3'd4
	} kind_t;

	typedef enum logic [0:0] {
		CFG_TERR_COUNT = 1'b0,
		CFG_CELL_SIZE  = 1'b1
	} cfg_idx_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DECODE, S_SETUP, S_TERR, S_LAT_A, S_RD_B, S_LAT_B, S_DIFF,
		S_MAG, S_CR, S_CR_FL, S_CR_EV, S_DOT, S_DOT_FL, S_DOT_EV, S_NEXT,
		S_ACCUM, S_RESP
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic              capture;
		logic              exec;
		logic              setup;
		logic              rd;
		logic              lat_a;
		logic              lat_b;
		logic              shift_ab;
		logic              diff;
		logic              mag;
		logic              acc_clr;
		logic              mul_en;
		logic              mul_dot;
		logic [2:0]        k;
		logic              cr_eval;
		logic              terr_init;
		logic              terr_done;
		logic              bnd;
		logic              accum;
		logic              load_out;
		logic [TERR_W:0]   t;
		logic [VTX_W-1:0]  v;
	} pta_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [2:0]        cmd;
		logic              dens_zero;
		logic [TERR_W:0]   terr_n;
		logic [VTX_W:0]    poly_n;
		logic              acc_zero;
		logic              acc_le0;
		logic              out_busy;
	} pta_status_t;

endpackage
`default_nettype wire

// ===== src/pta_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pta_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pta_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== src/pta_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pta_ctrl: sequencer of the territory assigner
// Walks territories and edges, steps the shared multiplier through its
// partial products and hands results to the output register.
// ----------------------------------------------------------------------------
module pta_ctrl import pta_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire pta_status_t sts,
	output pta_cmd_t         ctl
);

	state_t            state_q, state_n;
	logic [TERR_W:0]   t_q, t_n;
	logic [VTX_W-1:0]  v_q, v_n;
	logic [2:0]        k_q, k_n;
	logic              last_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			t_q     <= '0;
			v_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_n;
			t_q     <= t_n;
			v_q     <= v_n;
			k_q     <= k_n;
		end
	end

	assign last_v = ({1'b0, v_q} == sts.poly_n - 1'b1);

	// next state and commands
	always_comb begin
		state_n  = state_q;
		t_n      = t_q;
		v_n      = v_q;
		k_n      = k_q;
		ctl      = '0;
		ctl.t    = t_q;
		ctl.v    = v_q;
		ctl.k    = k_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				ctl.capture = in_valid;
				if (in_valid) begin
					state_n = S_DECODE;
				end
			end
			S_DECODE: begin
				if (sts.cmd == CMD_CLASSIFY && !sts.dens_zero) begin
					state_n = S_SETUP;
				end else begin
					ctl.exec = 1'b1;
					state_n  = S_RESP;
				end
			end
			S_SETUP: begin
				ctl.setup = 1'b1;
				t_n       = '0;
				state_n   = S_TERR;
			end
			S_TERR: begin
				ctl.v = VTX_W'(sts.poly_n - 1'b1);
				if (t_q == sts.terr_n) begin
					state_n = S_ACCUM;
				end else if (sts.poly_n == '0) begin
					t_n = t_q + 1'b1;
				end else begin
					ctl.rd        = 1'b1;
					ctl.terr_init = 1'b1;
					v_n           = '0;
					state_n       = S_LAT_A;
				end
			end
			S_LAT_A: begin
				ctl.lat_a = 1'b1;
				state_n   = S_RD_B;
			end
			S_RD_B: begin
				ctl.rd  = 1'b1;
				state_n = S_LAT_B;
			end
			S_LAT_B: begin
				ctl.lat_b = 1'b1;
				state_n   = S_DIFF;
			end
			S_DIFF: begin
				ctl.diff = 1'b1;
				state_n  = S_MAG;
			end
			S_MAG: begin
				ctl.mag     = 1'b1;
				ctl.acc_clr = 1'b1;
				k_n         = '0;
				state_n     = S_CR;
			end
			S_CR: begin
				ctl.mul_en = 1'b1;
				k_n        = k_q + 1'b1;
				if (k_q == 3'd7) begin
					state_n = S_CR_FL;
				end
			end
			S_CR_FL: begin
				state_n = S_CR_EV;
			end
			S_CR_EV: begin
				ctl.cr_eval = 1'b1;
				if (sts.acc_zero) begin
					ctl.acc_clr = 1'b1;
					k_n         = '0;
					state_n     = S_DOT;
				end else begin
					state_n = S_NEXT;
				end
			end
			S_DOT: begin
				ctl.mul_en  = 1'b1;
				ctl.mul_dot = 1'b1;
				k_n         = k_q + 1'b1;
				if (k_q == 3'd7) begin
					state_n = S_DOT_FL;
				end
			end
			S_DOT_FL: begin
				state_n = S_DOT_EV;
			end
			S_DOT_EV: begin
				if (sts.acc_le0) begin
					// center on this edge: boundary hit ends the territory
					ctl.terr_done = 1'b1;
					ctl.bnd       = 1'b1;
					t_n           = t_q + 1'b1;
					state_n       = S_TERR;
				end else begin
					state_n = S_NEXT;
				end
			end
			S_NEXT: begin
				ctl.shift_ab = 1'b1;
				if (last_v) begin
					ctl.terr_done = 1'b1;
					t_n           = t_q + 1'b1;
					state_n       = S_TERR;
				end else begin
					v_n     = v_q + 1'b1;
					state_n = S_RD_B;
				end
			end
			S_ACCUM: begin
				ctl.accum = 1'b1;
				state_n   = S_RESP;
			end
			S_RESP: begin
				if (!sts.out_busy) begin
					ctl.load_out = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_out |-> !sts.out_busy)
		else $error("result loaded while output still held");
	a_terr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TERR |-> t_q <= sts.terr_n)
		else $error("territory counter ran past territory count");
	a_vtx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD_B |-> {1'b0, v_q} < sts.poly_n)
		else $error("vertex read beyond polygon size");
`endif

endmodule
`default_nettype wire

// ===== src/pta_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pta_dp: datapath of the territory assigner
// Vertex RAM, edge differences, shared chunked multiplier with accumulator,
// per-classify bookkeeping, class statistics and the output register.
// ----------------------------------------------------------------------------
module pta_dp import pta_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire pta_cmd_t                 ctl,
	output pta_status_t                   sts,
	input  wire logic                     cfg_wr_en,
	input  wire logic [0:0]               cfg_addr,
	input  wire logic [CSIZE_W-1:0]       cfg_wdata,
	input  wire logic [2:0]               command,
	input  wire logic [4:0]               slot,
	input  wire logic [VTX_W-1:0]         vertex_index,
	input  wire logic [VTX_W:0]           vertex_count,
	input  wire logic signed [COORD_W-1:0] vertex_x,
	input  wire logic signed [COORD_W-1:0] vertex_y,
	input  wire logic signed [CELL_W-1:0] cell_x,
	input  wire logic signed [CELL_W-1:0] cell_y,
	input  wire logic [7:0]               density,
	input  wire logic                     out_ready,
	output logic                          out_valid,
	output logic [2:0]                    kind,
	output logic [TERR_W-1:0]             territory_index,
	output logic [MAX_TERR-1:0]           inside_mask,
	output logic [CNT_W-1:0]              cells_total,
	output logic [SUM_W-1:0]              density_sum
);

	// held transaction
	logic [2:0]                cmd_q;
	logic [4:0]                slot_q;
	logic [VTX_W-1:0]          vidx_q;
	logic [VTX_W:0]            vcnt_q;
	logic signed [COORD_W-1:0] vx_q, vy_q;
	logic signed [CELL_W-1:0]  cx_q, cy_q;
	logic [7:0]                dens_q;

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q  <= command;
			slot_q <= slot;
			vidx_q <= vertex_index;
			vcnt_q <= vertex_count;
			vx_q   <= vertex_x;
			vy_q   <= vertex_y;
			cx_q   <= cell_x;
			cy_q   <= cell_y;
			dens_q <= density;
		end
	end

	// configuration registers
	logic [TERR_W:0]    terr_count_q;
	logic [CSIZE_W-1:0] cell_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			terr_count_q <= '0;
			cell_size_q  <= CELL_SIZE_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				CFG_TERR_COUNT: terr_count_q <= cfg_wdata[TERR_W:0];
				CFG_CELL_SIZE:  cell_size_q  <= cfg_wdata;
				default:        ;
			endcase
		end
	end

	// polygon sizes
	logic [VTX_W:0] poly_size_q [MAX_TERR];
	logic           slot_terr;

	assign slot_terr = (slot_q < 5'(MAX_TERR));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TERR; i++) begin
				poly_size_q[i] <= '0;
			end
		end else if (ctl.exec && cmd_q == CMD_SET_COUNT && slot_terr) begin
			poly_size_q[slot_q[TERR_W-1:0]] <= (vcnt_q > (VTX_W+1)'(MAX_VTX)) ?
				(VTX_W+1)'(MAX_VTX) : vcnt_q;
		end
	end

	// vertex store, x in the upper half
	logic [2*COORD_W-1:0] vram_rdata;

	pta_ram #(.WIDTH(2 * COORD_W), .DEPTH(VSTORE_D)) u_vram (
		.clk   (clk),
		.we    (ctl.exec && cmd_q == CMD_WRITE_VTX && slot_terr),
		.waddr ({slot_q[TERR_W-1:0], vidx_q}),
		.wdata ({vx_q, vy_q}),
		.re    (ctl.rd),
		.raddr ({ctl.t[TERR_W-1:0], ctl.v}),
		.rdata (vram_rdata)
	);

	// cell center
	logic signed [COORD_W-1:0]       px_q, py_q;
	logic signed [CELL_W+CSIZE_W:0]  prod_x, prod_y, half;

	always_comb begin
		prod_x = $signed(cx_q) * $signed({1'b0, cell_size_q});
		prod_y = $signed(cy_q) * $signed({1'b0, cell_size_q});
		half   = $signed({{(CELL_W+2){1'b0}}, cell_size_q[CSIZE_W-1:1]});
	end

	always_ff @(posedge clk) begin
		if (ctl.setup) begin
			px_q <= COORD_W'(prod_x + half);
			py_q <= COORD_W'(prod_y + half);
		end
	end

	// edge end points
	logic signed [COORD_W-1:0] ax_q, ay_q, bx_q, by_q;

	always_ff @(posedge clk) begin
		if (ctl.lat_a) begin
			ax_q <= vram_rdata[2*COORD_W-1:COORD_W];
			ay_q <= vram_rdata[COORD_W-1:0];
		end else if (ctl.shift_ab) begin
			ax_q <= bx_q;
			ay_q <= by_q;
		end
		if (ctl.lat_b) begin
			bx_q <= vram_rdata[2*COORD_W-1:COORD_W];
			by_q <= vram_rdata[COORD_W-1:0];
		end
	end

	// differences: bx-ax, py-ay, by-ay, px-ax, px-bx, py-by
	logic signed [DIFF_W-1:0] d_q [NUM_DIFF];
	logic [DIFF_W-1:0]        m_q [NUM_DIFF];
	logic [NUM_DIFF-1:0]      s_q;
	logic                     straddle_q, dyab_pos_q;

	always_ff @(posedge clk) begin
		if (ctl.diff) begin
			d_q[0] <= DIFF_W'(bx_q) - DIFF_W'(ax_q);
			d_q[1] <= DIFF_W'(py_q) - DIFF_W'(ay_q);
			d_q[2] <= DIFF_W'(by_q) - DIFF_W'(ay_q);
			d_q[3] <= DIFF_W'(px_q) - DIFF_W'(ax_q);
			d_q[4] <= DIFF_W'(px_q) - DIFF_W'(bx_q);
			d_q[5] <= DIFF_W'(py_q) - DIFF_W'(by_q);
		end
		if (ctl.mag) begin
			for (int i = 0; i < NUM_DIFF; i++) begin
				s_q[i] <= d_q[i][DIFF_W-1];
				m_q[i] <= d_q[i][DIFF_W-1] ? DIFF_W'(-d_q[i]) : DIFF_W'(d_q[i]);
			end
			// edge spans the ray's row: (ay > py) != (by > py)
			straddle_q <= d_q[1][DIFF_W-1] != d_q[5][DIFF_W-1];
			dyab_pos_q <= !d_q[2][DIFF_W-1] && (d_q[2] != '0);
		end
	end

	// operand pair per product
	logic [2:0]         ia, ib;
	logic               sub;
	logic [DIFF_W-1:0]  ma, mb;
	logic [CHUNK_W-1:0] a_chunk, b_chunk;

	always_comb begin
		unique case ({ctl.mul_dot, ctl.k[2]})
			2'b00: begin ia = 3'd0; ib = 3'd1; sub = 1'b0; end
			2'b01: begin ia = 3'd2; ib = 3'd3; sub = 1'b1; end
			2'b10: begin ia = 3'd3; ib = 3'd4; sub = 1'b0; end
			2'b11: begin ia = 3'd1; ib = 3'd5; sub = 1'b0; end
			default: begin ia = 3'd0; ib = 3'd0; sub = 1'b0; end
		endcase
		ma      = m_q[ia];
		mb      = m_q[ib];
		a_chunk = ctl.k[1] ? CHUNK_W'(ma[DIFF_W-1:CHUNK_W]) : ma[CHUNK_W-1:0];
		b_chunk = ctl.k[0] ? CHUNK_W'(mb[DIFF_W-1:CHUNK_W]) : mb[CHUNK_W-1:0];
	end

	// partial product stage
	logic [PROD_W-1:0] pp_s1;
	logic [1:0]        sh_s1;
	logic              neg_s1, en_s1;

	always_ff @(posedge clk) begin
		pp_s1  <= a_chunk * b_chunk;
		sh_s1  <= {ctl.k[1] & ctl.k[0], ctl.k[1] ^ ctl.k[0]};
		neg_s1 <= s_q[ia] ^ s_q[ib] ^ sub;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1 <= 1'b0;
		end else begin
			en_s1 <= ctl.mul_en;
		end
	end

	// accumulate signed, shifted partial products
	logic [ACC_W-1:0] term, acc_q;

	always_comb begin
		unique case (sh_s1)
			2'd0:    term = ACC_W'(pp_s1);
			2'd1:    term = ACC_W'(pp_s1) << CHUNK_W;
			2'd2:    term = ACC_W'(pp_s1) << (2 * CHUNK_W);
			default: term = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.acc_clr) begin
			acc_q <= '0;
		end else if (en_s1) begin
			acc_q <= acc_q + (term ^ {ACC_W{neg_s1}}) + ACC_W'(neg_s1);
		end
	end

	logic acc_zero, acc_neg, hit;

	assign acc_zero = (acc_q == '0);
	assign acc_neg  = acc_q[ACC_W-1];
	assign hit      = straddle_q && (dyab_pos_q ? (!acc_neg && !acc_zero) : acc_neg);

	// per-classify bookkeeping
	logic                 inside_q, have_bd_q;
	logic [1:0]           in_cnt_q;
	logic [TERR_W-1:0]    first_in_q, first_bd_q;
	logic [MAX_TERR-1:0]  mask_q;

	always_ff @(posedge clk) begin
		if (ctl.terr_init) begin
			inside_q <= 1'b0;
		end else if (ctl.cr_eval && hit) begin
			inside_q <= !inside_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cnt_q   <= '0;
			have_bd_q  <= 1'b0;
			first_in_q <= '0;
			first_bd_q <= '0;
			mask_q     <= '0;
		end else if (ctl.setup) begin
			in_cnt_q   <= '0;
			have_bd_q  <= 1'b0;
			first_in_q <= '0;
			first_bd_q <= '0;
			mask_q     <= '0;
		end else if (ctl.terr_done) begin
			if (ctl.bnd) begin
				if (!have_bd_q) begin
					have_bd_q  <= 1'b1;
					first_bd_q <= ctl.t[TERR_W-1:0];
				end
			end else if (inside_q) begin
				mask_q[ctl.t[TERR_W-1:0]] <= 1'b1;
				if (in_cnt_q == 2'd0) begin
					first_in_q <= ctl.t[TERR_W-1:0];
				end
				if (in_cnt_q != 2'd2) begin
					in_cnt_q <= in_cnt_q + 1'b1;
				end
			end
		end
	end

	// classification
	logic [CLS_W-1:0]  cls;
	kind_t             cls_kind;
	logic [TERR_W-1:0] cls_tidx;

	always_comb begin
		priority if (in_cnt_q == 2'd2) begin
			cls = CLS_OVERLAP;              cls_kind = KIND_OVERLAP;    cls_tidx = '0;
		end else if (in_cnt_q == 2'd1) begin
			cls = {1'b0, first_in_q};       cls_kind = KIND_TERRITORY;  cls_tidx = first_in_q;
		end else if (have_bd_q) begin
			cls = {1'b0, first_bd_q};       cls_kind = KIND_TERRITORY;  cls_tidx = first_bd_q;
		end else begin
			cls = CLS_UNASSIGNED;           cls_kind = KIND_UNASSIGNED; cls_tidx = '0;
		end
	end

	// class statistics, one shared read index
	logic [CNT_W-1:0] cnt_q [CLASS_SLOTS];
	logic [SUM_W-1:0] sum_q [CLASS_SLOTS];
	logic [CLS_W-1:0] st_idx;
	logic             st_ok;
	logic [CNT_W-1:0] cnt_rd, cnt_inc;
	logic [SUM_W-1:0] sum_rd, sum_inc;
	logic [SUM_W:0]   sum_wide;

	always_comb begin
		st_idx   = ctl.accum ? cls : slot_q;
		st_ok    = (st_idx < CLS_W'(CLASS_SLOTS));
		cnt_rd   = st_ok ? cnt_q[st_idx] : '0;
		sum_rd   = st_ok ? sum_q[st_idx] : '0;
		cnt_inc  = (cnt_rd == '1) ? cnt_rd : cnt_rd + 1'b1;
		sum_wide = {1'b0, sum_rd} + (SUM_W+1)'(dens_q);
		sum_inc  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CLASS_SLOTS; i++) begin
				cnt_q[i] <= '0;
				sum_q[i] <= '0;
			end
		end else if (ctl.exec && cmd_q == CMD_CLEAR_STATS) begin
			for (int i = 0; i < CLASS_SLOTS; i++) begin
				cnt_q[i] <= '0;
				sum_q[i] <= '0;
			end
		end else if (ctl.accum) begin
			cnt_q[cls] <= cnt_inc;
			sum_q[cls] <= sum_inc;
		end
	end

	kind_t             res_kind_q;
	logic [TERR_W-1:0] res_tidx_q;

	always_ff @(posedge clk) begin
		if (ctl.accum) begin
			res_kind_q <= cls_kind;
			res_tidx_q <= cls_tidx;
		end
	end

	// output register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			kind            <= KIND_DONE;
			territory_index <= '0;
			inside_mask     <= '0;
			cells_total     <= '0;
			density_sum     <= '0;
			if (cmd_q == CMD_CLASSIFY) begin
				if (dens_q == '0) begin
					kind <= KIND_SKIPPED;
				end else begin
					kind            <= res_kind_q;
					territory_index <= res_tidx_q;
					inside_mask     <= mask_q;
				end
			end else if (cmd_q == CMD_READ_STATS) begin
				cells_total <= cnt_rd;
				density_sum <= sum_rd;
			end
		end
	end

	assign out_valid = out_valid_q;

	// status to the controller
	always_comb begin
		sts.cmd       = cmd_q;
		sts.dens_zero = (dens_q == '0);
		sts.terr_n    = (terr_count_q > (TERR_W+1)'(MAX_TERR)) ?
			(TERR_W+1)'(MAX_TERR) : terr_count_q;
		sts.poly_n    = poly_size_q[ctl.t[TERR_W-1:0]];
		sts.acc_zero  = acc_zero;
		sts.acc_le0   = acc_neg || acc_zero;
		sts.out_busy  = out_valid_q && !out_ready;
	end

`ifndef SYNTHESIS
	a_acc_clash: assert property (@(posedge clk) disable iff (!arst_n)
		en_s1 |-> !ctl.acc_clr)
		else $error("accumulator cleared while a partial product lands");
	a_mask_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		in_cnt_q == 2'd0 |-> mask_q == '0)
		else $error("inside mask set with no inside territory counted");
`endif

endmodule
`default_nettype wire

// ===== src/polygon_territory_assigner_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// polygon_territory_assigner_top: grid cell to polygon territory classifier
// Even-odd ray casting with exact boundary test over up to 16 polygons.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one command per transaction:
//   vertex write, vertex count, classify cell, read stats, clear stats.
//   Output channel (out_valid/out_ready) returns exactly one result per
//   command. The config port (cfg_wr_en/cfg_addr/cfg_wdata) sets territory
//   count and cell size; write it only while the block is idle.
//   One command is worked at a time. Non-classify commands and zero-density
//   cells skip the edge walk. A classify walks the edges of each territory
//   in turn, with an extra test for each edge whose line holds the center;
//   its pace is set by the single vertex RAM read port and the shared
//   25x25 multiplier, which forms every 49x49 product in four partial
//   products.
//   The finished result sits in the output register; a new command is taken
//   while it waits, and the next result waits until the receiver takes it.
//   Reset clears polygon sizes and statistics and resets config (territory
//   count 0, cell size 25600); vertex RAM contents are undefined until written.
// ----------------------------------------------------------------------------
module polygon_territory_assigner_top import pta_pkg::*; (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_wr_en,
	input  wire logic [0:0]                cfg_addr,
	input  wire logic [CSIZE_W-1:0]        cfg_wdata,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [2:0]                command,
	input  wire logic [4:0]                slot,
	input  wire logic [VTX_W-1:0]          vertex_index,
	input  wire logic [VTX_W:0]            vertex_count,
	input  wire logic signed [COORD_W-1:0] vertex_x,
	input  wire logic signed [COORD_W-1:0] vertex_y,
	input  wire logic signed [CELL_W-1:0]  cell_x,
	input  wire logic signed [CELL_W-1:0]  cell_y,
	input  wire logic [7:0]                density,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [2:0]                     kind,
	output logic [TERR_W-1:0]              territory_index,
	output logic [MAX_TERR-1:0]            inside_mask,
	output logic [CNT_W-1:0]               cells_total,
	output logic [SUM_W-1:0]               density_sum
);

	pta_cmd_t    ctl;
	pta_status_t sts;

	pta_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	pta_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.sts             (sts),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_addr        (cfg_addr),
		.cfg_wdata       (cfg_wdata),
		.command         (command),
		.slot            (slot),
		.vertex_index    (vertex_index),
		.vertex_count    (vertex_count),
		.vertex_x        (vertex_x),
		.vertex_y        (vertex_y),
		.cell_x          (cell_x),
		.cell_y          (cell_y),
		.density         (density),
		.out_ready       (out_ready),
		.out_valid       (out_valid),
		.kind            (kind),
		.territory_index (territory_index),
		.inside_mask     (inside_mask),
		.cells_total     (cells_total),
		.density_sum     (density_sum)
	);

endmodule
`default_nettype wire
